// ----- hw/rtl/gpd_pkg.sv -----
// Package with register indexes, reset values and a channel helper of the gradient decoder.
`default_nettype none

package gpd_pkg;

  // Field and register widths.
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned RW_W     = 12;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned PACKED_W = 3 * CHAN_W;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_RECT_WIDTH  = 3'd0,
    REG_RED_MAX     = 3'd1,
    REG_GREEN_MAX   = 3'd2,
    REG_BLUE_MAX    = 3'd3,
    REG_RED_SHIFT   = 3'd4,
    REG_GREEN_SHIFT = 3'd5,
    REG_BLUE_SHIFT  = 3'd6
  } reg_index_t;

  // Values after reset (RGB565 layout).
  localparam logic [RW_W-1:0]    RST_RECT_WIDTH  = 12'd1;
  localparam logic [CHAN_W-1:0]  RST_RED_MAX     = 8'd31;
  localparam logic [CHAN_W-1:0]  RST_GREEN_MAX   = 8'd63;
  localparam logic [CHAN_W-1:0]  RST_BLUE_MAX    = 8'd31;
  localparam logic [SHIFT_W-1:0] RST_RED_SHIFT   = 4'd11;
  localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT = 4'd5;
  localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT  = 4'd0;

  // Reconstructs one channel from its residual and its three neighbors.
  function automatic logic [CHAN_W-1:0] chan_decode(
    input logic [PIX_W-1:0]   res,
    input logic [SHIFT_W-1:0] sh,
    input logic [CHAN_W-1:0]  maxv,
    input logic [CHAN_W-1:0]  above,
    input logic [CHAN_W-1:0]  left,
    input logic [CHAN_W-1:0]  aleft
  );
    logic signed [CHAN_W+1:0] est;
    logic [CHAN_W-1:0]        pred;
    logic [PIX_W-1:0]         res_sh;
    est = $signed({2'b00, above}) + $signed({2'b00, left}) - $signed({2'b00, aleft});
    if (est > $signed({2'b00, maxv})) begin
      pred = maxv;
    end else if (est < 0) begin
      pred = '0;
    end else begin
      pred = est[CHAN_W-1:0];
    end
    res_sh = res >> sh;
    return (res_sh[CHAN_W-1:0] + pred) & maxv;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gradient_predictor_pixel_decode.sv -----
// Top level of the gradient-predictor pixel decoder with row store and output register.
`default_nettype none

// Decodes one gradient-filtered 16-bit pixel per clock in raster order while the
// output is not stalled. A pixel with s_tuser high starts a new rectangle. A
// pixel passes from its input transfer to stage 1 and then to the output register.
// Stage 1 holds the registered read of the row store (one write and one read
// port), with the previous pixel forwarded when it is the row entry just being
// written. Output stalls hold the pixel in place and stop the input only while
// both registers are full.
// The row store needs no clearing after reset; configuration must be written only
// while no pixel is in flight, which the block itself does not enforce.
module gradient_predictor_pixel_decode
  import gpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input stream.
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [PIX_W-1:0]   s_tdata,   // [15:0] residual_pixel
  input  wire logic               s_tuser,   // [0] rect_start
  // Output stream.
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [PIX_W-1:0]        m_tdata,   // [15:0] pixel_out
  // Configuration write port.
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned NXT_W = COL_W + 1;
  localparam int unsigned CMP_W = (NXT_W > RW_W) ? NXT_W : RW_W;
  localparam logic [NXT_W-1:0] MAX_W_N = NXT_W'(MAX_WIDTH);

  // Configuration registers.
  logic [RW_W-1:0]    rect_width;
  logic [CHAN_W-1:0]  red_max, green_max, blue_max;
  logic [SHIFT_W-1:0] red_shift, green_shift, blue_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_width  <= RST_RECT_WIDTH;
      red_max     <= RST_RED_MAX;
      green_max   <= RST_GREEN_MAX;
      blue_max    <= RST_BLUE_MAX;
      red_shift   <= RST_RED_SHIFT;
      green_shift <= RST_GREEN_SHIFT;
      blue_shift  <= RST_BLUE_SHIFT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECT_WIDTH:  rect_width  <= cfg_data[RW_W-1:0];
        REG_RED_MAX:     red_max     <= cfg_data[CHAN_W-1:0];
        REG_GREEN_MAX:   green_max   <= cfg_data[CHAN_W-1:0];
        REG_BLUE_MAX:    blue_max    <= cfg_data[CHAN_W-1:0];
        REG_RED_SHIFT:   red_shift   <= cfg_data[SHIFT_W-1:0];
        REG_GREEN_SHIFT: green_shift <= cfg_data[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  blue_shift  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid, s1_fire, s_accept;
  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign s_accept = s_tvalid && s_tready;

  // Raster position of the incoming pixel and of the one after it.
  logic [COL_W-1:0] column_position, col_in, col_in_next;
  logic             in_first_row, first_in, first_in_next;
  logic [NXT_W-1:0] col_step;
  logic             row_wrap;

  always_comb begin
    col_in   = s_tuser ? '0 : column_position;
    first_in = s_tuser || in_first_row;
    col_step = {1'b0, col_in} + NXT_W'(1);
    // A zero width wraps after every pixel; widths past the store wrap at its end.
    row_wrap = (CMP_W'(col_step) >= CMP_W'(rect_width)) || (col_step == MAX_W_N);
    if (row_wrap) begin
      col_in_next   = '0;
      first_in_next = 1'b0;
    end else begin
      col_in_next   = col_step[COL_W-1:0];
      first_in_next = first_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      in_first_row    <= 1'b1;
    end else if (s_accept) begin
      column_position <= col_in_next;
      in_first_row    <= first_in_next;
    end
  end

  // Stage 1 registers: the pixel, its position and the row store read.
  logic [PIX_W-1:0]    s1_res;
  logic [COL_W-1:0]    s1_col;
  logic                s1_first, s1_fwd;
  logic [PACKED_W-1:0] row_store [MAX_WIDTH];
  logic [PACKED_W-1:0] row_q;
  logic [PACKED_W-1:0] packed_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_res   <= s_tdata;
      s1_col   <= col_in;
      s1_first <= first_in;
      // The entry written at this edge is not in the read data; take it from left.
      s1_fwd   <= s1_fire && (s1_col == col_in);
      row_q    <= row_store[col_in];
    end
    if (s1_fire) begin
      row_store[s1_col] <= packed_px;
    end
  end

  // Neighbors of the pixel in stage 1.
  logic [PACKED_W-1:0] left_channels, above_left_channels;
  logic [PACKED_W-1:0] above, left, aleft;
  logic [PIX_W-1:0]    pixel;
  logic [CHAN_W-1:0]   r_ch, g_ch, b_ch;

  always_comb begin
    if (s1_first) begin
      above = '0;
    end else if (s1_fwd) begin
      above = left_channels;
    end else begin
      above = row_q;
    end
    if (s1_col == '0) begin
      left  = '0;
      aleft = '0;
    end else begin
      left  = left_channels;
      aleft = above_left_channels;
    end
  end

  // Predict and reconstruct the three channels, then repack the pixel.
  always_comb begin
    r_ch = chan_decode(s1_res, red_shift, red_max,
                       above[23:16], left[23:16], aleft[23:16]);
    g_ch = chan_decode(s1_res, green_shift, green_max,
                       above[15:8], left[15:8], aleft[15:8]);
    b_ch = chan_decode(s1_res, blue_shift, blue_max,
                       above[7:0], left[7:0], aleft[7:0]);
    packed_px = {r_ch, g_ch, b_ch};
    pixel = ({8'h00, r_ch} << red_shift) | ({8'h00, g_ch} << green_shift)
          | ({8'h00, b_ch} << blue_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_channels       <= '0;
      above_left_channels <= '0;
    end else if (s1_fire) begin
      left_channels       <= packed_px;
      above_left_channels <= above;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= pixel;
    end
  end

  // The column counter never leaves the row store.
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    NXT_W'(column_position) < MAX_W_N)
    else $error("column position beyond row store");

  // A rectangle start lands in stage 1 at column zero on the first row.
  a_rect_start: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tuser |=> s1_valid && (s1_col == '0) && s1_first)
    else $error("rectangle start not restarting position");

  // A pixel leaving stage 1 is presented on the output next cycle.
  a_fire_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid)
    else $error("decoded pixel lost");

  // A pixel that reads the row entry being written at the same edge takes the forward.
  a_fwd_col: assert property (@(posedge clk) disable iff (rst)
    s_accept && s1_fire && (s1_col == col_in) |=> s1_fwd)
    else $error("row store forward missed");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the gradient-predictor pixel decoder.
`timescale 1ns / 100ps

module tb_top;
  import gpd_pkg::*;

  localparam int ROW_MAX = 2048;

  // One configuration setting and the pixel run sent under it.
  typedef struct {
    logic [RW_W-1:0]    width;
    logic [CHAN_W-1:0]  rmax;
    logic [CHAN_W-1:0]  gmax;
    logic [CHAN_W-1:0]  bmax;
    logic [SHIFT_W-1:0] rsh;
    logic [SHIFT_W-1:0] gsh;
    logic [SHIFT_W-1:0] bsh;
    int                 count;
    bit                 calm;
    bit                 starts;
  } phase_t;

  // Directed pixel with an optional hand-typed expected pixel.
  typedef struct {
    logic [PIX_W-1:0] res;
    logic             start;
    bit               known;
    logic [PIX_W-1:0] pix;
  } pixel_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Decoder state as the testbench sees it.
  logic [RW_W-1:0]     cfg_width;
  logic [CHAN_W-1:0]   chan_max [3];
  logic [SHIFT_W-1:0]  chan_shift [3];
  logic [PACKED_W-1:0] row_mem [ROW_MAX];
  bit                  row_written [ROW_MAX];
  logic [RW_W-1:0]     col_pos;
  bit                  first_row;
  logic [PACKED_W-1:0] left_chans;
  logic [PACKED_W-1:0] aleft_chans;

  logic [PIX_W-1:0] expected_pixels [$];
  int               mismatch_count = 0;
  int               stall_left = 0;
  bit               calm = 1'b0;

  gradient_predictor_pixel_decode #(.MAX_WIDTH(ROW_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [15:0] residual_pixel
    .s_tuser   (s_tuser),   // [0] rect_start
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [15:0] pixel_out
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: mostly short, sometimes medium, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Reconstructs one pixel and advances the row store, neighbors and column.
  function automatic logic [PIX_W-1:0] decode_pixel(input logic [PIX_W-1:0] res,
                                                     input logic start);
    logic [RW_W-1:0]     col;
    logic [PACKED_W-1:0] above;
    logic [PACKED_W-1:0] left_nb;
    logic [PACKED_W-1:0] aleft_nb;
    logic [PACKED_W-1:0] chans;
    logic [31:0]         pixel;
    logic [31:0]         sum;
    logic [CHAN_W-1:0]   ch;
    int                  est;
    int                  wid;
    if (start) begin
      col_pos = '0;
      first_row = 1'b1;
    end
    col = (col_pos >= ROW_MAX) ? RW_W'(ROW_MAX - 1) : col_pos;
    above = first_row ? '0 : row_mem[col];
    if (col == 0) begin
      left_nb = '0;
      aleft_nb = '0;
    end else begin
      left_nb = left_chans;
      aleft_nb = aleft_chans;
    end
    chans = '0;
    pixel = '0;
    // Red sits in the top byte of the stored triple, blue in the bottom one.
    for (int k = 0; k < 3; k++) begin
      est = int'(above[16-8*k +: 8]) + int'(left_nb[16-8*k +: 8])
            - int'(aleft_nb[16-8*k +: 8]);
      if (est > int'(chan_max[k])) begin
        est = int'(chan_max[k]);
      end else if (est < 0) begin
        est = 0;
      end
      sum = (32'(res) >> chan_shift[k]) + 32'(est);
      ch = sum[7:0] & chan_max[k];
      chans[16-8*k +: 8] = ch;
      pixel = pixel | (32'(ch) << chan_shift[k]);
    end
    row_mem[col] = chans;
    row_written[col] = 1'b1;
    left_chans = chans;
    aleft_chans = above;
    // Zero width acts as one pixel, oversize width as the store depth.
    if (cfg_width == 0) begin
      wid = 1;
    end else if (cfg_width > ROW_MAX) begin
      wid = ROW_MAX;
    end else begin
      wid = int'(cfg_width);
    end
    col_pos = col + 1'b1;
    if (int'(col_pos) >= wid) begin
      col_pos = '0;
      first_row = 1'b0;
    end
    return pixel[PIX_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
                               input logic [PIX_W-1:0] want);
    $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // One input transfer; the expected pixel is queued when it is accepted.
  task automatic push_pixel(input logic [PIX_W-1:0] res, input logic start,
                            input bit known, input logic [PIX_W-1:0] typed);
    int              gap;
    logic [RW_W-1:0] col;
    logic [PIX_W-1:0] pix;
    // Never read a row entry that nothing has written: start afresh instead.
    col = (col_pos >= ROW_MAX) ? RW_W'(ROW_MAX - 1) : col_pos;
    if (!start && !first_row && !row_written[col]) begin
      start = 1'b1;
    end
    gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= res;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    pix = decode_pixel(res, start);
    expected_pixels.push_back(known ? typed : pix);
    @(negedge clk);
  endtask

  // Stops the sender and holds until every expected pixel has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RECT_WIDTH:  cfg_width = val[RW_W-1:0];
      REG_RED_MAX:     chan_max[0] = val[CHAN_W-1:0];
      REG_GREEN_MAX:   chan_max[1] = val[CHAN_W-1:0];
      REG_BLUE_MAX:    chan_max[2] = val[CHAN_W-1:0];
      REG_RED_SHIFT:   chan_shift[0] = val[SHIFT_W-1:0];
      REG_GREEN_SHIFT: chan_shift[1] = val[SHIFT_W-1:0];
      REG_BLUE_SHIFT:  chan_shift[2] = val[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Writes every register, then sends the phase's pixels and drains.
  task automatic run_phase(input phase_t ph);
    logic start;
    set_reg(REG_RECT_WIDTH, CFG_W'(ph.width));
    set_reg(REG_RED_MAX, CFG_W'(ph.rmax));
    set_reg(REG_GREEN_MAX, CFG_W'(ph.gmax));
    set_reg(REG_BLUE_MAX, CFG_W'(ph.bmax));
    set_reg(REG_RED_SHIFT, CFG_W'(ph.rsh));
    set_reg(REG_GREEN_SHIFT, CFG_W'(ph.gsh));
    set_reg(REG_BLUE_SHIFT, CFG_W'(ph.bsh));
    cfg_we <= 1'b0;
    calm = ph.calm;
    for (int i = 0; i < ph.count; i++) begin
      if (i == 0) begin
        start = ph.starts ? 1'($urandom_range(0, 1)) : 1'b1;
      end else begin
        start = ph.starts && ($urandom_range(0, 99) < 2);
      end
      push_pixel(16'($urandom_range(0, 65535)), start, 1'b0, '0);
    end
    drain();
  endtask

  function automatic logic [CHAN_W-1:0] pick_max();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd31;
      3: return 8'd63;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic phase_t random_phase();
    phase_t ph;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      ph.width = '0;
    end else if (r < 10) begin
      ph.width = 12'($urandom_range(ROW_MAX, 4095));
    end else if (r < 20) begin
      ph.width = 12'($urandom_range(25, 300));
    end else begin
      ph.width = 12'($urandom_range(1, 24));
    end
    ph.rmax = pick_max();
    ph.gmax = pick_max();
    ph.bmax = pick_max();
    ph.rsh = 4'($urandom_range(0, 15));
    ph.gsh = 4'($urandom_range(0, 15));
    ph.bsh = 4'($urandom_range(0, 15));
    ph.count = $urandom_range(50, 110);
    ph.calm = ($urandom_range(0, 99) < 15);
    ph.starts = 1'b1;
    return ph;
  endfunction

  // Output side: random backpressure, sampled on the rising edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Compare each output transfer with the oldest expected pixel.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        flag_mismatch("pixel with none expected", m_tdata, '0);
      end else if (m_tdata !== expected_pixels[0]) begin
        flag_mismatch("pixel_out", m_tdata, expected_pixels.pop_front());
      end else begin
        void'(expected_pixels.pop_front());
      end
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    // Under the reset layout (RGB565, one pixel per row) each pixel sits below
    // the previous one, so the first few results follow by hand.
    static pixel_row_t directed [12] = '{
      '{16'h0000, 1'b1, 1'b1, 16'h0000},
      '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
      '{16'h0000, 1'b0, 1'b1, 16'hFFFF},
      '{16'hFFFF, 1'b0, 1'b1, 16'hF7DE},
      '{16'h8000, 1'b0, 1'b0, 16'h0000},
      '{16'h0001, 1'b0, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b1, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 1'b0, 16'h0000},
      '{16'h0821, 1'b0, 1'b0, 16'h0000}
    };
    // Extremes: zero width, an oversize width, then a width cut mid-row,
    // all-zero and all-ones masks, and the top and bottom shifts.
    static phase_t fixed [5] = '{
      '{12'd0,    8'd255, 8'd255, 8'd255, 4'd0,  4'd0,  4'd0,  60,  1'b0, 1'b1},
      '{12'd4095, 8'd31,  8'd63,  8'd31,  4'd11, 4'd5,  4'd0,  300, 1'b0, 1'b0},
      '{12'd5,    8'd0,   8'd0,   8'd0,   4'd15, 4'd15, 4'd15, 60,  1'b0, 1'b1},
      '{12'd2048, 8'd255, 8'd255, 8'd255, 4'd15, 4'd8,  4'd0,  80,  1'b1, 1'b1},
      '{12'd1,    8'd255, 8'd127, 8'd1,   4'd0,  4'd7,  4'd15, 40,  1'b1, 1'b0}
    };

    cfg_width = RST_RECT_WIDTH;
    chan_max[0] = RST_RED_MAX;
    chan_max[1] = RST_GREEN_MAX;
    chan_max[2] = RST_BLUE_MAX;
    chan_shift[0] = RST_RED_SHIFT;
    chan_shift[1] = RST_GREEN_SHIFT;
    chan_shift[2] = RST_BLUE_SHIFT;
    col_pos = '0;
    first_row = 1'b1;
    left_chans = '0;
    aleft_chans = '0;
    for (int i = 0; i < ROW_MAX; i++) begin
      row_written[i] = 1'b0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      push_pixel(directed[i].res, directed[i].start, directed[i].known, directed[i].pix);
    end
    drain();

    foreach (fixed[i]) begin
      run_phase(fixed[i]);
    end
    for (int i = 0; i < 13; i++) begin
      run_phase(random_phase());
    end

    calm = 1'b1;
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- gradient_predictor_pixel_decode.f -----
hw/rtl/gpd_pkg.sv
hw/rtl/gradient_predictor_pixel_decode.sv
sim/tb_top.sv
